### rtl/alm_pkg.sv
// Package for the array linked list manager: sizes, command and status codes,
// sequencer states and the node memory layout. No dependencies.
`default_nettype none
package alm_pkg;
  localparam int Capacity  = 64;
  localparam int SlotBits  = 6;
  localparam int PosBits   = 7;
  localparam int ElemBits  = 32;
  localparam int NodeBits  = 1 + PosBits + ElemBits;
  localparam logic [PosBits-1:0] NIL = 7'd64;

  typedef enum logic [2:0] {
    CMD_ADD_FRONT = 3'd0,
    CMD_ADD_END   = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_READ      = 3'd4,
    CMD_WRITE     = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_BAD       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_STEP,
    S_LINK,
    S_WALK,
    S_DONE
  } state_t;

  // one entry of the node memory
  typedef struct packed {
    logic                in_use;
    logic [PosBits-1:0]  bwd;
    logic [ElemBits-1:0] value;
  } node_t;
endpackage
`default_nettype wire

### rtl/alm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module alm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrBits = $clog2(Depth)
) (
  input  wire logic                clk,
  input  wire logic                wen,
  input  wire logic [AddrBits-1:0] waddr,
  input  wire logic [Width-1:0]    wdata,
  input  wire logic [AddrBits-1:0] raddr,
  output      logic [Width-1:0]    rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/array_linked_list_manager.sv
// Array linked list manager: doubly linked list in slot memories.
// States after accept: read/overwrite and errors go read, evaluate, done; add and
// remove go read, evaluate, link, done; insert adds a step before the link; search
// walks from the head to a match or the end. Words are taken only in idle; a result
// held in the output register lets the next word in and stalls only its done state.
// Reset: rst (synchronous) sets head and tail to NIL, clears length, free head and the
// per-slot touched bits; an untouched slot reads as free with forward link i+1.
`default_nettype none
module array_linked_list_manager (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [47:0] s_tdata,  // command[2:0], position[9:3], value[41:10]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [55:0] m_tdata   // status[1:0], elem_out[33:2], position_out[40:34],
                                     // count[47:41], head_position[54:48]
);
  import alm_pkg::*;

  state_t state, state_next;
  cmd_t                cmd;
  logic [PosBits-1:0]  pos;
  logic [ElemBits-1:0] val;
  logic [PosBits-1:0]  head, tail, free_head, length;
  logic [Capacity-1:0] touched;
  logic [PosBits-1:0]  cur, nx_q;
  logic [PosBits-1:0]  bk_slot, bk_link, fw_slot, fw_link;
  status_t             w_status;
  logic [ElemBits-1:0] w_elem;
  logic [PosBits-1:0]  w_pout;
  logic                out_valid;
  logic [54:0]         out_word;

  // node memory {in_use, backward, value} and forward link memory
  logic                node_wen, fwd_wen;
  logic [SlotBits-1:0] node_waddr, node_raddr, fwd_waddr, fwd_raddr, fwd_raddr_q;
  node_t               node_wdata, node_rd;
  logic [NodeBits-1:0] node_rdata;
  logic [PosBits-1:0]  fwd_wdata, fwd_raw, fwd_rd;

  alm_ram #(.Width(NodeBits), .Depth(Capacity)) u_node (
    .clk, .wen(node_wen), .waddr(node_waddr), .wdata(node_wdata), .raddr(node_raddr),
    .rdata(node_rdata));
  alm_ram #(.Width(PosBits), .Depth(Capacity)) u_fwd (
    .clk, .wen(fwd_wen), .waddr(fwd_waddr), .wdata(fwd_wdata), .raddr(fwd_raddr),
    .rdata(fwd_raw));

  assign node_rd = node_t'(node_rdata);
  // untouched slot still holds its reset link i+1
  assign fwd_rd = touched[fwd_raddr_q] ? fwd_raw : ({1'b0, fwd_raddr_q} + 7'd1);

  logic [SlotBits-1:0] fs, ps, hs;
  assign fs = free_head[SlotBits-1:0];
  assign ps = pos[SlotBits-1:0];
  assign hs = head[SlotBits-1:0];

  logic pos_ok, full;
  assign pos_ok = !pos[SlotBits] && touched[ps] && node_rd.in_use;
  assign full   = free_head[SlotBits];
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_word};

  always_comb begin
    state_next = state;
    node_raddr = ps;
    fwd_raddr  = ps;
    node_wen = 1'b0; node_waddr = fs; node_wdata = '{1'b1, NIL, val};
    fwd_wen = 1'b0; fwd_waddr = fs; fwd_wdata = NIL;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_READ;
      S_READ: begin
        case (cmd)
          CMD_ADD_FRONT: begin
            node_raddr = hs;
            fwd_raddr = fs;
          end
          CMD_ADD_END: fwd_raddr = fs;
          CMD_SEARCH: begin
            node_raddr = hs;
            fwd_raddr = hs;
          end
          default: ;
        endcase
        if (cmd == CMD_SEARCH) state_next = head[SlotBits] ? S_DONE : S_WALK;
        else state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_DONE;
        case (cmd)
          CMD_ADD_FRONT, CMD_ADD_END: if (!full) begin
            // old head entry is read again so its value survives the backward-link rewrite
            node_raddr = hs;
            node_wen = 1'b1;
            node_wdata = '{1'b1, (cmd == CMD_ADD_END) ? tail : NIL, val};
            fwd_wen = 1'b1;
            fwd_wdata = (cmd == CMD_ADD_FRONT) ? head : NIL;
            state_next = S_LINK;
          end
          CMD_INSERT: if (pos_ok && !full) begin
            fwd_raddr = fs;
            state_next = S_STEP;
          end
          CMD_REMOVE: if (pos_ok) begin
            node_raddr = fwd_rd[SlotBits-1:0];
            node_wen = 1'b1; node_waddr = ps;
            node_wdata = '{1'b0, node_rd.bwd, node_rd.value};
            fwd_wen = 1'b1; fwd_waddr = ps; fwd_wdata = free_head;
            state_next = S_LINK;
          end
          CMD_WRITE: if (pos_ok) begin
            node_wen = 1'b1; node_waddr = ps;
            node_wdata = '{1'b1, node_rd.bwd, val};
          end
          default: ;
        endcase
      end
      S_STEP: begin
        node_raddr = nx_q[SlotBits-1:0];
        node_wen = 1'b1; node_wdata = '{1'b1, pos, val};
        fwd_wen = 1'b1; fwd_wdata = nx_q;
        state_next = S_LINK;
      end
      S_LINK: begin
        // neighbor fixups: backward link of one slot, forward link of another
        if (!bk_slot[SlotBits]) begin
          node_wen = 1'b1; node_waddr = bk_slot[SlotBits-1:0];
          node_wdata = '{1'b1, bk_link, node_rd.value};
        end
        if (!fw_slot[SlotBits]) begin
          fwd_wen = 1'b1; fwd_waddr = fw_slot[SlotBits-1:0];
          fwd_wdata = fw_link;
        end
        state_next = S_DONE;
      end
      S_WALK: begin
        node_raddr = fwd_rd[SlotBits-1:0];
        fwd_raddr  = fwd_rd[SlotBits-1:0];
        if (node_rd.value == val || fwd_rd[SlotBits]) state_next = S_DONE;
      end
      S_DONE: if (!out_valid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    fwd_raddr_q <= fwd_raddr;
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      head <= NIL; tail <= NIL; free_head <= '0; length <= '0;
      touched <= '0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
        out_word  <= {head, length, w_pout, w_elem, w_status};
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (s_tvalid) begin
          cmd <= cmd_t'(s_tdata[2:0]); pos <= s_tdata[9:3]; val <= s_tdata[41:10];
          w_status <= ST_OK; w_elem <= '0; w_pout <= NIL;
        end
        S_READ: if (cmd == CMD_SEARCH) begin
          cur <= head;
          if (head[SlotBits]) w_status <= ST_NOT_FOUND;
        end
        S_EVAL: begin
          case (cmd)
            CMD_ADD_FRONT, CMD_ADD_END: if (full) w_status <= ST_FULL;
              else begin
                touched[fs] <= 1'b1;
                free_head <= fwd_rd; length <= length + 7'd1; w_pout <= free_head;
                if (cmd == CMD_ADD_FRONT) begin
                  head <= free_head;
                  if (head[SlotBits]) tail <= free_head;
                  bk_slot <= head; bk_link <= free_head; fw_slot <= NIL;
                end else begin
                  tail <= free_head;
                  if (tail[SlotBits]) head <= free_head;
                  fw_slot <= tail; fw_link <= free_head; bk_slot <= NIL;
                end
              end
            CMD_INSERT: if (!pos_ok) w_status <= ST_INVALID;
              else if (full) w_status <= ST_FULL;
              else nx_q <= fwd_rd;
            CMD_REMOVE: if (!pos_ok) w_status <= ST_INVALID;
              else begin
                free_head <= pos; length <= length - 7'd1;
                w_elem <= node_rd.value; w_pout <= fwd_rd;
                if (node_rd.bwd[SlotBits]) head <= fwd_rd;
                if (fwd_rd[SlotBits]) tail <= node_rd.bwd;
                fw_slot <= node_rd.bwd; fw_link <= fwd_rd;
                bk_slot <= fwd_rd; bk_link <= node_rd.bwd;
              end
            CMD_READ, CMD_WRITE: if (!pos_ok) w_status <= ST_INVALID;
              else w_elem <= node_rd.value;
            default: w_status <= ST_INVALID;
          endcase
        end
        S_STEP: begin
          // free slot's forward link is on the read port now
          touched[fs] <= 1'b1;
          free_head <= fwd_rd; length <= length + 7'd1; w_pout <= free_head;
          if (nx_q[SlotBits]) tail <= free_head;
          bk_slot <= nx_q; bk_link <= free_head;
          fw_slot <= pos; fw_link <= free_head;
        end
        S_WALK: begin
          if (node_rd.value == val) w_pout <= cur;
          else if (fwd_rd[SlotBits]) w_status <= ST_NOT_FOUND;
          cur <= fwd_rd;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) length <= 7'(Capacity))
    else $error("length above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_READ)
    else $error("accepted item did not start");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (head == NIL) == (length == 7'd0))
    else $error("head and length disagree");
endmodule
`default_nettype wire
